### rtl/multi_agent_waypoint_follower_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the waypoint follower controller
// ---------------------------------------------------------------------------
`ifndef MULTI_AGENT_WAYPOINT_FOLLOWER_DEFINES_SVH
`define MULTI_AGENT_WAYPOINT_FOLLOWER_DEFINES_SVH

// implication checked every cycle outside reset
`define MAWF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define MAWF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mawf_pkg.sv
// ---------------------------------------------------------------------------
// mawf_pkg
// Types and constants of the multi-agent waypoint follower.
// ---------------------------------------------------------------------------
package mawf_pkg;

  localparam logic [1:0] KIND_POS  = 2'd0;
  localparam logic [1:0] KIND_PUSH = 2'd1;
  localparam logic [1:0] KIND_MODE = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_TAKEOFF  = 3'd1;
  localparam logic [2:0] MODE_LAND     = 3'd2;
  localparam logic [2:0] MODE_MOVE     = 3'd3;
  localparam logic [2:0] MODE_VELMOVE  = 3'd4;
  localparam logic [2:0] MODE_HOVER    = 3'd5;
  localparam logic [2:0] MODE_TRACKING = 3'd6;

  localparam logic CFG_REACH = 1'b0;
  localparam logic CFG_SPEED = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic apply_item;  // write a non-tick request to agent state
    logic load_agent;  // latch agent state of the current visit
    logic calc;        // compute distance and velocity terms
    logic start_sqrt;  // start the root unit
    logic start_div;   // start one component division
    logic [1:0] div_sel;
    logic commit;      // write back agent state, build the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic need_scale;  // velmove with the speed limit active
  } sts_t;

endpackage

### rtl/multi_agent_waypoint_follower.sv
// A position, push or mode request is applied while idle and gives no result.
// A tick gives one result per agent; an agent whose velmove needs scaling also runs
// an 18-step root unit and then one 33-step divider three times, once per component.
// The next request waits until the tick over all agents is done.
// Reset (rst_n low, synchronous) clears agent state, queues, the controller, the
// configuration and output valid registers; RAM content and data registers are left as is.
// ---------------------------------------------------------------------------
// multi_agent_waypoint_follower
// Per-agent flight sequencer with waypoint queues and velocity command.
// ---------------------------------------------------------------------------
module multi_agent_waypoint_follower #(
  parameter int NUM_AGENTS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // kind, agent, coord_x, coord_y, coord_z, link_up, new_mode
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // agent_id, mode, linked, done_res, drive_valid,
                                  // vel_x, vel_y, vel_z, hold_height
  output logic        out_tlast
);
  localparam int AW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);

  // configuration registers
  logic [15:0] reach_r, speed_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= 16'd100;
      speed_r <= 16'd500;
    end else if (cfg_we) begin
      if (cfg_index == mawf_pkg::CFG_REACH) reach_r <= cfg_wdata;
      else speed_r <= cfg_wdata;
    end
  end

  mawf_pkg::cmd_t cmd;
  mawf_pkg::sts_t sts;
  logic [AW-1:0]  visit_agent;
  logic           visit_last;
  logic [75:0]    res_data;

  mawf_ctrl #(.NUM_AGENTS(NUM_AGENTS), .AW(AW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_kind(in_tdata[1:0]),
    .in_ready(in_tready), .res_busy(out_tvalid && !out_tready),
    .visit_agent(visit_agent), .visit_last(visit_last), .cmd(cmd), .sts(sts)
  );

  mawf_dpath #(.NUM_AGENTS(NUM_AGENTS), .QUEUE_DEPTH(QUEUE_DEPTH), .AW(AW), .QW(QW))
  u_dpath (
    .clk(clk), .rst_n(rst_n), .it_agent(in_tdata[4:2]), .it_kind(in_tdata[1:0]),
    .it_x(in_tdata[20:5]), .it_y(in_tdata[36:21]), .it_z(in_tdata[52:37]),
    .it_link(in_tdata[53]), .it_mode(in_tdata[56:54]),
    .reach_thr(reach_r), .spd_lim(speed_r), .visit_agent(visit_agent),
    .cmd(cmd), .sts(sts), .res_data(res_data)
  );

  // output register: hold result until taken
  logic vld_r, last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.commit) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.commit) last_r <= visit_last;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {4'd0, res_data};
  assign out_tlast  = last_r;
endmodule

### rtl/mawf_ram.sv
// ---------------------------------------------------------------------------
// mawf_ram
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mawf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/mawf_ctrl.sv
// ---------------------------------------------------------------------------
// mawf_ctrl
// Sequencer: takes requests, walks agents on a tick, runs sqrt and divisions.
// ---------------------------------------------------------------------------
`include "multi_agent_waypoint_follower_defines.svh"
module mawf_ctrl #(
  parameter int NUM_AGENTS = 8,
  parameter int AW = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_kind,
  output logic             in_ready,
  input  logic             res_busy,
  output logic [AW-1:0]    visit_agent,
  output logic             visit_last,
  output mawf_pkg::cmd_t   cmd,
  input  mawf_pkg::sts_t   sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_LOAD = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] agent_r, agent_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic          div_go_r, div_go_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign visit_agent = agent_r;
  assign visit_last  = (32'(agent_r) == NUM_AGENTS - 1);

  always_comb begin
    state_nxt  = state_r;
    agent_nxt  = agent_r;
    comp_nxt   = comp_r;
    div_go_nxt = 1'b0;
    cmd        = '0;
    cmd.div_sel = comp_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == mawf_pkg::KIND_TICK) begin
            agent_nxt = '0;
            state_nxt = S_READ;
          end else begin
            cmd.apply_item = 1'b1;
          end
        end
      end
      S_READ: begin
        // RAM read issued from agent index; the registered data is ready in S_LOAD
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_agent = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (!sts.need_scale) begin
          state_nxt = S_WB;
        end else begin
          cmd.start_sqrt = !div_go_r;
          div_go_nxt = 1'b1;
          if (div_go_r && sts.sqrt_done) begin
            comp_nxt = 2'd0;
            state_nxt = S_DIV;
            div_go_nxt = 1'b0;
          end
        end
      end
      S_DIV: begin
        cmd.start_div = !div_go_r;
        div_go_nxt = 1'b1;
        if (div_go_r && sts.div_done) begin
          div_go_nxt = 1'b0;
          if (comp_r == 2'd2) begin
            state_nxt = S_WB;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      S_WB: begin
        // hold until the output register is free
        if (!res_busy) begin
          cmd.commit = 1'b1;
          if (visit_last) begin
            state_nxt = S_IDLE;
          end else begin
            agent_nxt = agent_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      agent_r  <= '0;
      comp_r   <= '0;
      div_go_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      agent_r  <= agent_nxt;
      comp_r   <= comp_nxt;
      div_go_r <= div_go_nxt;
    end
  end

  `MAWF_ASSERT_IMP(a_commit_free, cmd.commit, !res_busy, "commit into busy output")
  `MAWF_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready, "ready while busy")
  `MAWF_ASSERT_NXT(a_last_ends, cmd.commit && visit_last, state_r == S_IDLE,
                   "tick did not end after last agent")
endmodule

### rtl/mawf_dpath.sv
// ---------------------------------------------------------------------------
// mawf_dpath
// Agent state, waypoint queues, distance, root and scaling units, result.
// ---------------------------------------------------------------------------
module mawf_dpath #(
  parameter int NUM_AGENTS = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int AW = 3,
  parameter int QW = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          it_agent,
  input  logic [1:0]          it_kind,
  input  logic signed [15:0]  it_x,
  input  logic signed [15:0]  it_y,
  input  logic signed [15:0]  it_z,
  input  logic                it_link,
  input  logic [2:0]          it_mode,
  input  logic [15:0]         reach_thr,
  input  logic [15:0]         spd_lim,
  input  logic [AW-1:0]       visit_agent,
  input  mawf_pkg::cmd_t      cmd,
  output mawf_pkg::sts_t      sts,
  output logic [75:0]         res_data
);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = AW + QW;

  logic [2:0]  mode_r  [NUM_AGENTS];
  logic        done_r  [NUM_AGENTS];
  logic        link_r  [NUM_AGENTS];
  logic [47:0] pos_r   [NUM_AGENTS];
  logic [47:0] tgt_r   [NUM_AGENTS];
  logic [QW-1:0] head_r [NUM_AGENTS];
  logic [CW-1:0] cnt_r  [NUM_AGENTS];

  logic          item_ok;
  logic [AW-1:0] ia;
  assign ia = AW'(it_agent);
  assign item_ok = (32'(it_agent) < NUM_AGENTS);

  // waypoint RAM
  logic          ram_we;
  logic [RW-1:0] ram_wa, ram_ra;
  logic [47:0]   ram_rd;
  logic [QW-1:0] slot;
  logic [CW:0]   slot_sum;
  // tail slot: head plus count, wrapped once past the queue end
  assign slot_sum = (CW+1)'(head_r[ia]) + (CW+1)'(cnt_r[ia]);
  assign slot     = (32'(slot_sum) >= QUEUE_DEPTH) ? QW'(32'(slot_sum) - QUEUE_DEPTH)
                                                   : QW'(slot_sum);
  assign ram_we = cmd.apply_item && item_ok && it_kind == mawf_pkg::KIND_PUSH
                  && 32'(cnt_r[ia]) < QUEUE_DEPTH;
  assign ram_wa = {ia, slot};
  assign ram_ra = {visit_agent, head_r[visit_agent]};

  mawf_ram #(.WIDTH(48), .DEPTH(1 << RW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata({it_z, it_y, it_x}),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  // visit registers
  logic [2:0]  vm_r;
  logic        vempty_r;
  logic [47:0] vpos_r, vtgt_r, wp_r;
  logic signed [16:0] dx_r, dy_r, dz_r;
  logic [34:0] d2_r;
  logic        reach_r, slow_r;
  logic signed [16:0] vx_r, vy_r, vz_r;

  always_ff @(posedge clk) begin
    if (cmd.load_agent) begin
      vm_r     <= mode_r[visit_agent];
      vempty_r <= (cnt_r[visit_agent] == '0);
      vpos_r   <= pos_r[visit_agent];
      vtgt_r   <= tgt_r[visit_agent];
      wp_r     <= ram_rd;
    end
  end

  // distance terms: one pass of three 17x17 multiplies into registers
  logic signed [16:0] ddx, ddy, ddz;
  assign ddx = 17'(signed'(wp_r[15:0]))  - 17'(signed'(vpos_r[15:0]));
  assign ddy = 17'(signed'(wp_r[31:16])) - 17'(signed'(vpos_r[31:16]));
  assign ddz = 17'(signed'(wp_r[47:32])) - 17'(signed'(vpos_r[47:32]));
  logic [33:0] sqx, sqy, sqz;
  assign sqx = 34'(ddx * ddx);
  assign sqy = 34'(ddy * ddy);
  assign sqz = 34'(ddz * ddz);

  logic [31:0] thr2, lim2;
  assign thr2 = 32'(reach_thr) * 32'(reach_thr);
  assign lim2 = 32'(spd_lim) * 32'(spd_lim);
  logic [34:0] d2_c;
  assign d2_c = 35'(sqx) + 35'(sqy) + 35'(sqz);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      dx_r <= ddx; dy_r <= ddy; dz_r <= ddz;
      d2_r <= d2_c;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      reach_r <= d2_c < 35'(thr2);
      slow_r  <= d2_c < 35'(lim2);
    end
  end

  assign sts.need_scale = (vm_r == mawf_pkg::MODE_VELMOVE) && !vempty_r && !reach_r
                          && !slow_r;

  // bit-serial square root, two bits per step; partial root needs full width
  logic [35:0] sq_n_r, sq_bit_r;
  logic [35:0] sq_root_r;
  logic        sq_busy_r;
  logic [35:0] sq_trial;
  assign sq_trial = sq_root_r + sq_bit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.start_sqrt) begin
      sq_n_r    <= 36'(d2_r);
      sq_bit_r  <= 36'h1 << 34;
      sq_root_r <= '0;
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r) begin
      if (sq_n_r >= sq_trial) begin
        sq_n_r    <= sq_n_r - sq_trial;
        sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
      if (sq_bit_r[0] || sq_bit_r == '0) sq_busy_r <= 1'b0;
    end
  end
  assign sts.sqrt_done = !sq_busy_r;

  // restoring divider: |d| * limit / root, one quotient bit per cycle
  logic signed [16:0] dsel;
  always_comb begin
    case (cmd.div_sel)
      2'd0:    dsel = dx_r;
      2'd1:    dsel = dy_r;
      default: dsel = dz_r;
    endcase
  end
  logic [16:0] dmag;
  assign dmag = dsel[16] ? 17'(-dsel) : 17'(dsel);
  logic [32:0] dv_rem_r, dv_num_r;
  logic [32:0] dv_q_r;
  logic [5:0]  dv_cnt_r;
  logic        dv_busy_r, dv_neg_r;
  logic [33:0] dv_trial;
  assign dv_trial = {dv_rem_r, dv_num_r[32]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (cmd.start_div) begin
      dv_num_r  <= 33'(dmag) * 33'(spd_lim);
      dv_rem_r  <= '0;
      dv_q_r    <= '0;
      dv_cnt_r  <= 6'd33;
      dv_neg_r  <= dsel[16];
      dv_busy_r <= 1'b1;
    end else if (dv_busy_r) begin
      dv_num_r <= dv_num_r << 1;
      if (sq_root_r != '0 && dv_trial >= 34'(sq_root_r)) begin
        dv_rem_r <= 33'(dv_trial - 34'(sq_root_r));
        dv_q_r   <= {dv_q_r[31:0], 1'b1};
      end else begin
        dv_rem_r <= 33'(dv_trial);
        dv_q_r   <= {dv_q_r[31:0], 1'b0};
      end
      dv_cnt_r <= dv_cnt_r - 6'd1;
      if (dv_cnt_r == 6'd1) dv_busy_r <= 1'b0;
    end
  end
  assign sts.div_done = !dv_busy_r && !cmd.start_div;

  logic signed [16:0] qv;
  assign qv = dv_neg_r ? 17'(-dv_q_r[16:0]) : 17'(dv_q_r[16:0]);
  // the final quotient bit lands in the cycle after the last step; capture it there
  logic dv_fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dv_fin_r <= 1'b0;
    else dv_fin_r <= dv_busy_r && dv_cnt_r == 6'd1;
  end
  always_ff @(posedge clk) begin
    if (dv_fin_r) begin
      case (cmd.div_sel)
        2'd0:    vx_r <= qv;
        2'd1:    vy_r <= qv;
        default: vz_r <= qv;
      endcase
    end
  end

  // tick decision
  logic        mv;
  logic [2:0]  m_nxt;
  logic        dn_set, pop, drive;
  logic signed [16:0] ox, oy, oz;
  logic signed [15:0] oh;
  assign mv = vm_r == mawf_pkg::MODE_TAKEOFF || vm_r == mawf_pkg::MODE_LAND
              || vm_r == mawf_pkg::MODE_MOVE || vm_r == mawf_pkg::MODE_VELMOVE;
  always_comb begin
    m_nxt = vm_r; dn_set = 1'b0; pop = 1'b0; drive = 1'b0;
    ox = '0; oy = '0; oz = '0; oh = '0;
    if (vm_r == mawf_pkg::MODE_HOVER) begin
      drive = 1'b1;
      ox = 17'(signed'(vtgt_r[15:0]))  - 17'(signed'(vpos_r[15:0]));
      oy = 17'(signed'(vtgt_r[31:16])) - 17'(signed'(vpos_r[31:16]));
      oz = 17'(signed'(vtgt_r[47:32])) - 17'(signed'(vpos_r[47:32]));
      oh = vtgt_r[47:32];
    end else if (mv) begin
      if (vempty_r) begin
        m_nxt = (vm_r == mawf_pkg::MODE_LAND) ? mawf_pkg::MODE_IDLE
                                              : mawf_pkg::MODE_HOVER;
        dn_set = 1'b1;
      end else if (reach_r) begin
        pop = 1'b1;
      end else if (vm_r == mawf_pkg::MODE_VELMOVE) begin
        drive = 1'b1;
        oh = wp_r[47:32];
        if (slow_r) begin
          ox = dx_r; oy = dy_r; oz = dz_r;
        end else begin
          ox = vx_r; oy = vy_r; oz = vz_r;
        end
      end
    end
  end

  logic [2:0] vid;
  assign vid = 3'(visit_agent);
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_data <= {oh, oz, oy, ox, drive, done_r[visit_agent] | dn_set,
                   link_r[visit_agent], m_nxt, vid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AGENTS; i++) begin
        mode_r[i] <= mawf_pkg::MODE_IDLE;
        done_r[i] <= 1'b0;
        link_r[i] <= 1'b0;
        pos_r[i]  <= '0;
        tgt_r[i]  <= '0;
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.apply_item && item_ok) begin
      case (it_kind)
        mawf_pkg::KIND_POS: begin
          pos_r[ia]  <= {it_z, it_y, it_x};
          link_r[ia] <= it_link;
        end
        mawf_pkg::KIND_PUSH: begin
          if (32'(cnt_r[ia]) < QUEUE_DEPTH) cnt_r[ia] <= cnt_r[ia] + CW'(1);
        end
        mawf_pkg::KIND_MODE: begin
          // drop the undefined mode code
          if (it_mode <= mawf_pkg::MODE_TRACKING) begin
            mode_r[ia] <= it_mode;
            done_r[ia] <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd.commit) begin
      mode_r[visit_agent] <= m_nxt;
      if (dn_set) done_r[visit_agent] <= 1'b1;
      if (pop) begin
        tgt_r[visit_agent]  <= wp_r;
        head_r[visit_agent] <= (32'(head_r[visit_agent]) == QUEUE_DEPTH - 1) ? QW'(0)
                               : head_r[visit_agent] + QW'(1);
        cnt_r[visit_agent]  <= cnt_r[visit_agent] - CW'(1);
      end
    end
  end
endmodule
